/* rtl/psds_pkg.sv */
// Shared types and constants of the point-set distance sum block.
// Used by psds_iter and point_set_distance_sum; depends on nothing.
package psds_pkg;

    localparam int DEFAULT_COORD_WIDTH    = 32;
    localparam int DEFAULT_COEF_FRAC_BITS = 14;

    localparam int COEF_W      = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int LEN_W       = 8;
    localparam int SUM_W       = 64;

    localparam logic signed [COEF_W-1:0] COEF_11_RESET = 16'sd16384;
    localparam logic signed [COEF_W-1:0] COEF_12_RESET = 16'sd16384;
    localparam logic signed [COEF_W-1:0] COEF_21_RESET = -16'sd16384;
    localparam logic signed [COEF_W-1:0] COEF_22_RESET = 16'sd16384;

    typedef enum logic [1:0] {
        MODE_EUCLID    = 2'd0,
        MODE_MANHATTAN = 2'd1,
        MODE_AFFINE    = 2'd2,
        MODE_CHEBYSHEV = 2'd3
    } metric_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_METRIC_MODE = 3'd0,
        REG_CENTER_X    = 3'd1,
        REG_CENTER_Y    = 3'd2,
        REG_COEF_11     = 3'd3,
        REG_COEF_12     = 3'd4,
        REG_COEF_21     = 3'd5,
        REG_COEF_22     = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_SQ1,
        S_SQ2,
        S_ROOT,
        S_DET,
        S_DETCHK,
        S_AM1,
        S_AM2,
        S_ADIV,
        S_ACC
    } state_t;

    typedef struct packed {
        logic             start;
        op_t              op;
        logic [LEN_W-1:0] len;
    } iter_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_stat_t;

endpackage

/* rtl/psds_iter.sv */
// Shared iterative arithmetic unit: shift-add multiply, restoring divide and
// restoring square root, one bit per cycle through one adder. Uses psds_pkg.
module psds_iter #(
    parameter int AW = 98
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  psds_pkg::iter_req_t   req,
    input  logic [AW-1:0]         opa,
    input  logic [AW-1:0]         opb,
    output psds_pkg::iter_stat_t  stat,
    output logic [AW-1:0]         result
);
    import psds_pkg::*;

    logic [AW-1:0]    a_reg, a_next, b_reg, b_next, r_reg, r_next, rem_reg, rem_next;
    op_t              op_reg, op_next;
    logic [LEN_W-1:0] len_reg, len_next, cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;

    logic [AW-1:0] x, y, yy;
    logic          sub;
    logic [AW:0]   sum_w;
    logic          fits;

    // One adder serves every operation; for subtraction bit AW is the no-borrow flag.
    always_comb begin
        case (op_reg)
            OP_DIV: begin
                x   = {rem_reg[AW-2:0], a_reg[AW-1]};
                y   = b_reg;
                sub = 1'b1;
            end
            OP_SQRT: begin
                x   = {rem_reg[AW-3:0], a_reg[AW-1:AW-2]};
                y   = {r_reg[AW-3:0], 2'b01};
                sub = 1'b1;
            end
            default: begin
                x   = r_reg;
                y   = b_reg[0] ? a_reg : '0;
                sub = 1'b0;
            end
        endcase
        yy    = sub ? ~y : y;
        sum_w = {1'b0, x} + {1'b0, yy} + {{AW{1'b0}}, sub};
        fits  = sum_w[AW];
    end

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        rem_next  = rem_reg;
        op_next   = op_reg;
        len_next  = len_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (!busy_reg && req.start) begin
            a_next    = opa;
            b_next    = opb;
            r_next    = '0;
            rem_next  = '0;
            op_next   = req.op;
            len_next  = req.len;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            case (op_reg)
                OP_DIV: begin
                    a_next   = a_reg << 1;
                    rem_next = fits ? sum_w[AW-1:0] : x;
                    r_next   = {r_reg[AW-2:0], fits};
                end
                OP_SQRT: begin
                    a_next   = a_reg << 2;
                    rem_next = fits ? sum_w[AW-1:0] : x;
                    r_next   = {r_reg[AW-2:0], fits};
                end
                default: begin
                    r_next = sum_w[AW-1:0];
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
            endcase
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == len_reg - 1'b1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
            len_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
            len_reg  <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        r_reg   <= r_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = r_reg;

endmodule

/* rtl/point_set_distance_sum.sv */
// Top level of the point-set distance sum block: configuration registers,
// sequencer, accumulator and result register. Uses psds_pkg and psds_iter.

// Points arrive one request at a time as signed Q16.16 coordinates; each
// point's distance from the configured centre is added to a 64-bit
// saturating sum, and the point marked last_point produces one result
// request carrying the sum and two sticky flags, after which the sum and the
// flags start again from zero. The block handles one point at a time and
// drops s_ready while it works. Euclidean points take two squarings and a
// square root, each one bit per cycle in the shared iterative unit. Affine
// points take four shift-add products of a 16-bit coefficient and two long
// divisions by the determinant, again one bit per cycle in that same unit.
// A finished result sits in an output register, so the next point is taken
// while it waits; only a second last point stalls until the first result is
// taken. A zero determinant in affine mode adds nothing, raises
// singular_basis and ends the point.
// Configuration writes are always ready and are meant to be issued while the
// block is idle.
module point_set_distance_sum #(
    parameter int COORD_WIDTH    = psds_pkg::DEFAULT_COORD_WIDTH,
    parameter int COEF_FRAC_BITS = psds_pkg::DEFAULT_COEF_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [psds_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [COORD_WIDTH-1:0]            cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [COORD_WIDTH-1:0]     s_point_x,
    input  logic signed [COORD_WIDTH-1:0]     s_point_y,
    input  logic                              s_last_point,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [psds_pkg::SUM_W-1:0]        m_total_length,
    output logic                              m_saturated,
    output logic                              m_singular_basis
);
    import psds_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int F    = COEF_FRAC_BITS;
    localparam int MW   = CW + 1;           // difference and magnitude width
    localparam int NW   = 2 * MW;           // radicand width
    localparam int PW   = CW + 17;          // width of |p - q| or p + q
    localparam int DNW  = PW + F;           // numerator width
    localparam int AW0  = (NW > DNW) ? NW : DNW;
    localparam int AW   = (AW0 > 34) ? AW0 : 34;
    localparam int MXW  = ((AW > SUM_W) ? AW : SUM_W) + 1;
    localparam int DETW = 2 * COEF_W + 1;

    // Configuration registers.
    metric_t                  mode_reg, mode_next;
    logic signed [CW-1:0]     cx_reg, cx_next, cy_reg, cy_next;
    logic signed [COEF_W-1:0] c11_reg, c11_next, c12_reg, c12_next;
    logic signed [COEF_W-1:0] c21_reg, c21_next, c22_reg, c22_next;

    // Sequencer and working registers.
    state_t                   state_reg, state_next;
    logic signed [MW-1:0]     dx_reg, dx_next, dy_reg, dy_next;
    logic [MW-1:0]            ax_reg, ax_next, ay_reg, ay_next;
    logic                     last_reg, last_next, half_reg, half_next;
    logic [NW-1:0]            t_reg, t_next;
    logic [PW-1:0]            p_reg, p_next;
    logic [SUM_W-1:0]         u_reg, u_next, d_reg, d_next;
    logic signed [2*COEF_W-1:0] detp_reg, detp_next;
    logic signed [DETW-1:0]   det_reg, det_next;

    // Accumulator and result register.
    logic [SUM_W-1:0]         sum_reg, sum_next, out_sum_reg, out_sum_next;
    logic                     sat_reg, sat_next, sing_reg, sing_next;
    logic                     out_sat_reg, out_sat_next, out_sing_reg, out_sing_next;
    logic                     m_valid_reg, m_valid_next;

    // Shared unit.
    iter_req_t                ureq;
    iter_stat_t               ustat;
    logic [AW-1:0]            uop_a, uop_b, ures;

    // Helper signals.
    logic                     accept, out_ok, sel_v, pn, qn;
    logic signed [COEF_W-1:0] pc, qc;
    logic signed [MW-1:0]     px_s, qy_s;
    logic [MW-1:0]            pxm, qym;
    logic [COEF_W-1:0]        pcm, qcm;
    logic [PW-1:0]            qv, comb_pq;
    logic [NW-1:0]            rad_sum;
    logic [DETW-1:0]          dm_w;
    logic [MXW-1:0]           q_ext;
    logic [SUM_W-1:0]         uval;
    logic [SUM_W:0]           t65, s65;
    logic [SUM_W-1:0]         new_sum;
    logic                     new_sat;
    logic signed [2*COEF_W-1:0] prod2;

    function automatic logic [COEF_W-1:0] mag16(input logic signed [COEF_W-1:0] v);
        mag16 = v[COEF_W-1] ? COEF_W'(-v) : v;
    endfunction

    assign accept    = s_valid && s_ready;
    assign out_ok    = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    // The v coordinate's operands are issued straight from the division state.
    assign sel_v = half_reg || (state_reg == S_ADIV);
    assign pc    = sel_v ? c11_reg : c22_reg;
    assign qc    = sel_v ? c21_reg : c12_reg;
    assign px_s  = sel_v ? dy_reg : dx_reg;
    assign qy_s  = sel_v ? dx_reg : dy_reg;
    assign pxm   = sel_v ? ay_reg : ax_reg;
    assign qym   = sel_v ? ax_reg : ay_reg;
    assign pcm   = mag16(pc);
    assign qcm   = mag16(qc);
    assign pn    = pc[COEF_W-1] != px_s[MW-1];
    assign qn    = !(qc[COEF_W-1] != qy_s[MW-1]);

    always_comb begin
        qv = ures[PW-1:0];
        if (pn == qn) begin
            comb_pq = p_reg + qv;
        end else if (p_reg >= qv) begin
            comb_pq = p_reg - qv;
        end else begin
            comb_pq = qv - p_reg;
        end
    end

    assign rad_sum = t_reg + ures[NW-1:0];
    assign dm_w    = det_reg[DETW-1] ? DETW'(-det_reg) : DETW'(det_reg);
    assign prod2   = c21_reg * c12_reg;

    // A quotient that does not fit 64 bits sticks at all ones.
    assign q_ext = MXW'(ures);
    assign uval  = (q_ext > MXW'({SUM_W{1'b1}})) ? {SUM_W{1'b1}} : q_ext[SUM_W-1:0];
    assign t65   = {1'b0, u_reg} + {1'b0, uval};

    assign s65     = {1'b0, sum_reg} + {1'b0, d_reg};
    assign new_sum = s65[SUM_W] ? {SUM_W{1'b1}} : s65[SUM_W-1:0];
    assign new_sat = sat_reg || s65[SUM_W] || (new_sum == {SUM_W{1'b1}});

    psds_iter #(
        .AW(AW)
    ) u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ureq),
        .opa     (uop_a),
        .opb     (uop_b),
        .stat    (ustat),
        .result  (ures)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_SETUP;
            end
            S_SETUP: begin
                case (mode_reg)
                    MODE_EUCLID: state_next = S_SQ1;
                    MODE_AFFINE: state_next = S_DET;
                    default:     state_next = S_ACC;
                endcase
            end
            S_SQ1: begin
                if (ustat.done) state_next = S_SQ2;
            end
            S_SQ2: begin
                if (ustat.done) state_next = S_ROOT;
            end
            S_ROOT: begin
                if (ustat.done) state_next = S_ACC;
            end
            S_DET: begin
                state_next = S_DETCHK;
            end
            S_DETCHK: begin
                state_next = (det_reg == '0) ? S_ACC : S_AM1;
            end
            S_AM1: begin
                if (ustat.done) state_next = S_AM2;
            end
            S_AM2: begin
                if (ustat.done) state_next = S_ADIV;
            end
            S_ADIV: begin
                if (ustat.done) state_next = half_reg ? S_ACC : S_AM1;
            end
            S_ACC: begin
                if (!last_reg || out_ok) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: input ready and requests to the shared unit.
    always_comb begin
        s_ready    = (state_reg == S_IDLE);
        ureq.start = 1'b0;
        ureq.op    = OP_MUL;
        ureq.len   = LEN_W'(COEF_W);
        uop_a      = AW'(pxm);
        uop_b      = AW'(pcm);
        case (state_reg)
            S_SETUP: begin
                ureq.start = (mode_reg == MODE_EUCLID);
                ureq.len   = LEN_W'(MW);
                uop_a      = AW'(ax_reg);
                uop_b      = AW'(ax_reg);
            end
            S_SQ1: begin
                ureq.start = ustat.done;
                ureq.len   = LEN_W'(MW);
                uop_a      = AW'(ay_reg);
                uop_b      = AW'(ay_reg);
            end
            S_SQ2: begin
                ureq.start = ustat.done;
                ureq.op    = OP_SQRT;
                ureq.len   = LEN_W'(MW);
                uop_a      = AW'(rad_sum) << (AW - NW);
                uop_b      = '0;
            end
            S_DETCHK: begin
                ureq.start = (det_reg != '0);
            end
            S_AM1: begin
                ureq.start = ustat.done;
                uop_a      = AW'(qym);
                uop_b      = AW'(qcm);
            end
            S_AM2: begin
                ureq.start = ustat.done;
                ureq.op    = OP_DIV;
                ureq.len   = LEN_W'(DNW);
                uop_a      = AW'(comb_pq) << (AW - PW);
                uop_b      = AW'(dm_w);
            end
            S_ADIV: begin
                ureq.start = ustat.done && !half_reg;
            end
            default: begin
                ureq.start = 1'b0;
            end
        endcase
    end

    // Datapath and configuration next values.
    always_comb begin
        mode_next     = mode_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        c11_next      = c11_reg;
        c12_next      = c12_reg;
        c21_next      = c21_reg;
        c22_next      = c22_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        last_next     = last_reg;
        half_next     = half_reg;
        t_next        = t_reg;
        p_next        = p_reg;
        u_next        = u_reg;
        d_next        = d_reg;
        detp_next     = detp_reg;
        det_next      = det_reg;
        sum_next      = sum_reg;
        sat_next      = sat_reg;
        sing_next     = sing_reg;
        out_sum_next  = out_sum_reg;
        out_sat_next  = out_sat_reg;
        out_sing_next = out_sing_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        if (cfg_valid && cfg_ready) begin
            case (reg_index_t'(cfg_index))
                REG_METRIC_MODE: mode_next = metric_t'(cfg_data[1:0]);
                REG_CENTER_X:    cx_next   = cfg_data;
                REG_CENTER_Y:    cy_next   = cfg_data;
                REG_COEF_11:     c11_next  = cfg_data[COEF_W-1:0];
                REG_COEF_12:     c12_next  = cfg_data[COEF_W-1:0];
                REG_COEF_21:     c21_next  = cfg_data[COEF_W-1:0];
                REG_COEF_22:     c22_next  = cfg_data[COEF_W-1:0];
                default: begin
                    mode_next = mode_reg;
                end
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    dx_next   = {s_point_x[CW-1], s_point_x} - {cx_reg[CW-1], cx_reg};
                    dy_next   = {s_point_y[CW-1], s_point_y} - {cy_reg[CW-1], cy_reg};
                    ax_next   = dx_next[MW-1] ? MW'(-dx_next) : MW'(dx_next);
                    ay_next   = dy_next[MW-1] ? MW'(-dy_next) : MW'(dy_next);
                    last_next = s_last_point;
                    half_next = 1'b0;
                end
            end
            S_SETUP: begin
                detp_next = c11_reg * c22_reg;
                if (mode_reg == MODE_MANHATTAN) begin
                    d_next = SUM_W'({1'b0, ax_reg} + {1'b0, ay_reg});
                end else begin
                    d_next = SUM_W'((ax_reg > ay_reg) ? ax_reg : ay_reg);
                end
            end
            S_SQ1: begin
                if (ustat.done) t_next = ures[NW-1:0];
            end
            S_ROOT: begin
                if (ustat.done) d_next = SUM_W'(ures[MW-1:0]);
            end
            S_DET: begin
                det_next = {detp_reg[2*COEF_W-1], detp_reg} - {prod2[2*COEF_W-1], prod2};
            end
            S_DETCHK: begin
                if (det_reg == '0) begin
                    d_next    = '0;
                    sing_next = 1'b1;
                end
            end
            S_AM1: begin
                if (ustat.done) p_next = ures[PW-1:0];
            end
            S_ADIV: begin
                if (ustat.done) begin
                    if (!half_reg) begin
                        u_next    = uval;
                        half_next = 1'b1;
                    end else begin
                        d_next = t65[SUM_W] ? {SUM_W{1'b1}} : t65[SUM_W-1:0];
                    end
                end
            end
            S_ACC: begin
                if (!last_reg) begin
                    sum_next = new_sum;
                    sat_next = new_sat;
                end else if (out_ok) begin
                    out_sum_next  = new_sum;
                    out_sat_next  = new_sat;
                    out_sing_next = sing_reg;
                    m_valid_next  = 1'b1;
                    sum_next      = '0;
                    sat_next      = 1'b0;
                    sing_next     = 1'b0;
                end
            end
            default: begin
                d_next = d_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mode_reg    <= MODE_EUCLID;
            cx_reg      <= '0;
            cy_reg      <= '0;
            c11_reg     <= COEF_11_RESET;
            c12_reg     <= COEF_12_RESET;
            c21_reg     <= COEF_21_RESET;
            c22_reg     <= COEF_22_RESET;
            half_reg    <= 1'b0;
            sum_reg     <= '0;
            sat_reg     <= 1'b0;
            sing_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
            c11_reg     <= c11_next;
            c12_reg     <= c12_next;
            c21_reg     <= c21_next;
            c22_reg     <= c22_next;
            half_reg    <= half_next;
            sum_reg     <= sum_next;
            sat_reg     <= sat_next;
            sing_reg    <= sing_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        last_reg     <= last_next;
        t_reg        <= t_next;
        p_reg        <= p_next;
        u_reg        <= u_next;
        d_reg        <= d_next;
        detp_reg     <= detp_next;
        det_reg      <= det_next;
        out_sum_reg  <= out_sum_next;
        out_sat_reg  <= out_sat_next;
        out_sing_reg <= out_sing_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_total_length   = out_sum_reg;
    assign m_saturated      = out_sat_reg;
    assign m_singular_basis = out_sing_reg;

    // The sequencer never starts the shared unit while it is still iterating.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ureq.start |-> !ustat.busy)
        else $error("shared unit started while busy");

    // One point at a time: ready drops right after a point is taken.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input ready right after an accepted point");

    // Emitting a result clears the accumulator and both sticky flags.
    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ACC && last_reg && out_ok)
        |=> (sum_reg == '0 && !sat_reg && !sing_reg))
        else $error("accumulator not cleared after a result");

    // A sum stuck at its maximum always carries the saturation flag.
    a_sat_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (sum_reg == {SUM_W{1'b1}}) |-> sat_reg)
        else $error("saturated sum without flag");

endmodule
